### sv/hvl2_pkg.sv
// ----------------------------------------------------------------------------
// hvl2_pkg: shared types, constants and float functions
// Holds the binary16 widening, the binary32 add and multiply (round to
// nearest even, subnormals kept) and the structs passed between modules.
// ----------------------------------------------------------------------------
package hvl2_pkg;

  localparam int HVL2_LANES   = 4;
  localparam int HVL2_LEFT    = HVL2_LANES - 1;
  localparam int FIFO_DEPTH   = 16;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] FP_ZERO = 32'h0000_0000;

  // Control that travels with one lane of a request.
  typedef struct packed {
    logic valid;
    logic acc_en;
    logic left_en;
    logic last;
  } lane_ctl_t;

  // What a lane hands to the merge stage at the end of a vector.
  typedef struct packed {
    logic        valid;
    logic        left_en;
    logic [31:0] sum;
    logic [31:0] p;
  } lane_fin_t;

  // A finished distance.
  typedef struct packed {
    logic        valid;
    logic [31:0] bits;
  } res_t;

  // Exact widening of a binary16 pattern to binary32.
  function automatic logic [31:0] hvl2_widen(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  lz;
    logic [10:0] mm;
    logic [7:0]  ex;
    logic [31:0] r;
    e  = h[14:10];
    m  = h[9:0];
    lz = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) lz = 4'(9 - i);
    end
    mm = 11'({1'b0, m} << (lz + 4'd1));
    ex = 8'd112 - {4'b0, lz};
    if (e == 5'd0) begin
      if (m == 10'd0) r = {h[15], 31'b0};
      else            r = {h[15], ex, mm[9:0], 13'b0};
    end else if (e == 5'h1F) begin
      r = {h[15], 8'hFF, m, 13'b0};
    end else begin
      r = {h[15], {3'b0, e} + 8'd112, m, 13'b0};
    end
    return r;
  endfunction

  // Binary32 addition, round to nearest even.
  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [31:0] x, y, r;
    logic [7:0]  ex, ey, dd, sh;
    logic [23:0] mx, my;
    logic [26:0] xe, ye0, ye, n;
    logic        st, up;
    logic [27:0] sum;
    logic [4:0]  lz;
    logic [9:0]  e10;
    logic [7:0]  ef;
    a_nan = (&a[30:23]) && (|a[22:0]);
    b_nan = (&b[30:23]) && (|b[22:0]);
    a_inf = (&a[30:23]) && !(|a[22:0]);
    b_inf = (&b[30:23]) && !(|b[22:0]);
    if (b[30:0] > a[30:0]) begin
      x = b; y = a;
    end else begin
      x = a; y = b;
    end
    ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx  = {x[30:23] != 8'd0, x[22:0]};
    my  = {y[30:23] != 8'd0, y[22:0]};
    dd  = ex - ey;
    xe  = {mx, 3'b0};
    ye0 = {my, 3'b0};
    if (dd >= 8'd27) begin
      ye = {26'b0, |my};
    end else begin
      st = |(ye0 & ((27'h1 << dd) - 27'h1));
      ye = (ye0 >> dd) | {26'b0, st};
    end
    if (x[31] ^ y[31]) sum = {1'b0, xe} - {1'b0, ye};
    else               sum = {1'b0, xe} + {1'b0, ye};
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (sum[i]) lz = 5'(26 - i);
    end
    sh = ({3'b0, lz} < (ex - 8'd1)) ? {3'b0, lz} : (ex - 8'd1);
    if (sum[27]) begin
      n   = {sum[27:2], sum[1] | sum[0]};
      e10 = {2'b0, ex} + 10'd1;
    end else begin
      n   = sum[26:0] << sh;
      e10 = {2'b0, ex} - {2'b0, sh};
    end
    ef = n[26] ? e10[7:0] : 8'd0;
    up = n[2] & (n[1] | n[0] | n[3]);
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      r = FP_QNAN;
    end else if (a_inf) begin
      r = a;
    end else if (b_inf) begin
      r = b;
    end else if (sum == 28'd0) begin
      r = {x[31] & y[31], 31'b0};
    end else if (e10 >= 10'd255) begin
      r = {x[31], 8'hFF, 23'b0};
    end else begin
      r = {x[31], 31'({ef, n[25:3]}) + 31'(up)};
    end
    return r;
  endfunction

  // Binary32 multiplication, round to nearest even.
  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic               s, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0]         ea, eb, ef;
    logic [23:0]        ma, mb, m;
    logic [47:0]        p, pn, pn2;
    logic [5:0]         lz;
    logic signed [10:0] e;
    logic [10:0]        rsh;
    logic               g, st, lost, up;
    logic [31:0]        r;
    s      = a[31] ^ b[31];
    a_nan  = (&a[30:23]) && (|a[22:0]);
    b_nan  = (&b[30:23]) && (|b[22:0]);
    a_inf  = (&a[30:23]) && !(|a[22:0]);
    b_inf  = (&b[30:23]) && !(|b[22:0]);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    p  = ma * mb;
    lz = 6'd47;
    for (int i = 0; i < 48; i++) begin
      if (p[i]) lz = 6'(47 - i);
    end
    pn  = p << lz;
    e   = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126 - $signed({5'b0, lz});
    rsh = 11'(11'sd1 - e);
    if (e <= 11'sd0) begin
      ef = 8'd0;
      if (rsh > 11'd48) begin
        pn2  = 48'd0;
        lost = 1'b1;
      end else begin
        lost = |(pn & ((48'h1 << rsh) - 48'h1));
        pn2  = pn >> rsh;
      end
    end else begin
      ef   = e[7:0];
      lost = 1'b0;
      pn2  = pn;
    end
    m  = pn2[47:24];
    g  = pn2[23];
    st = (|pn2[22:0]) | lost;
    up = g & (st | m[0]);
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      r = FP_QNAN;
    end else if (a_inf || b_inf) begin
      r = {s, 8'hFF, 23'b0};
    end else if (a_zero || b_zero) begin
      r = {s, 31'b0};
    end else if (e >= 11'sd255) begin
      r = {s, 8'hFF, 23'b0};
    end else begin
      r = {s, 31'({ef, m[22:0]}) + 31'(up)};
    end
    return r;
  endfunction

endpackage

### sv/hvl2_in_if.sv
// ----------------------------------------------------------------------------
// hvl2_in_if: request channel
// Four element pairs of binary16 patterns with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hvl2_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] a_lane0;
  logic [15:0] a_lane1;
  logic [15:0] a_lane2;
  logic [15:0] a_lane3;
  logic [15:0] b_lane0;
  logic [15:0] b_lane1;
  logic [15:0] b_lane2;
  logic [15:0] b_lane3;

  modport source (
    output valid, a_lane0, a_lane1, a_lane2, a_lane3,
    output b_lane0, b_lane1, b_lane2, b_lane3,
    input  ready
  );
  modport sink (
    input  valid, a_lane0, a_lane1, a_lane2, a_lane3,
    input  b_lane0, b_lane1, b_lane2, b_lane3,
    output ready
  );
endinterface

### sv/hvl2_out_if.sv
// ----------------------------------------------------------------------------
// hvl2_out_if: result channel
// One binary32 distance pattern with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hvl2_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance_bits;

  modport source (output valid, distance_bits, input ready);
  modport sink (input valid, distance_bits, output ready);
endinterface

### sv/hvl2_lane.sv
// ----------------------------------------------------------------------------
// hvl2_lane: one element lane
// Widens and subtracts a pair, squares the difference and keeps the lane's
// running binary32 sum. Hands the sum and its last square on at vector end.
// ----------------------------------------------------------------------------
module hvl2_lane
  import hvl2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clr,
  input  lane_ctl_t   ctl,
  input  logic [15:0] a,
  input  logic [15:0] b,
  output lane_fin_t   fin
);

  lane_ctl_t   ctl_a_r, ctl_b_r;
  logic [31:0] d_r, p_r, sum_r, sum_nxt;
  lane_fin_t   fin_r;

  // Difference of the widened elements, then its square.
  always_ff @(posedge clk) begin
    d_r <= fp_add(hvl2_widen(a), hvl2_widen(b) ^ 32'h8000_0000);
    p_r <= fp_mul(d_r, d_r);
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else begin
      ctl_a_r <= ctl;
      ctl_b_r <= ctl_a_r;
    end
  end

  // Accumulate inside the body of the vector.
  always_comb begin
    sum_nxt = (ctl_b_r.valid && ctl_b_r.acc_en) ? fp_add(sum_r, p_r) : sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      sum_r       <= FP_ZERO;
      fin_r.valid <= 1'b0;
    end else if (ctl_b_r.valid && ctl_b_r.last) begin
      sum_r       <= FP_ZERO;
      fin_r.valid <= 1'b1;
    end else begin
      sum_r       <= sum_nxt;
      fin_r.valid <= 1'b0;
    end
    fin_r.sum     <= sum_nxt;
    fin_r.p       <= p_r;
    fin_r.left_en <= ctl_b_r.left_en;
  end

  assign fin = fin_r;

endmodule

### sv/hvl2_merge.sv
// ----------------------------------------------------------------------------
// hvl2_merge: lane merge
// Forms (l0+l1)+(l2+l3), then adds the leftover squares in element order,
// one registered add per stage.
// ----------------------------------------------------------------------------
module hvl2_merge
  import hvl2_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  lane_fin_t fin [HVL2_LANES],
  output res_t      res
);

  logic                        v1_r;
  logic [31:0]                 s01_r, s23_r;
  logic [HVL2_LEFT-1:0]        lf1_r;
  logic [HVL2_LEFT-1:0][31:0]  pp1_r;
  logic                        v_r   [HVL2_LEFT+1];
  logic [31:0]                 t_r   [HVL2_LEFT+1];
  logic [HVL2_LEFT-1:0]        lf_r  [HVL2_LEFT+1];
  logic [HVL2_LEFT-1:0][31:0]  pp_r  [HVL2_LEFT+1];
  logic [31:0]                 fin_bits;

  // Pairwise lane sums.
  always_ff @(posedge clk) begin
    s01_r <= fp_add(fin[0].sum, fin[1].sum);
    s23_r <= fp_add(fin[2].sum, fin[3].sum);
    for (int k = 0; k < HVL2_LEFT; k++) begin
      lf1_r[k] <= fin[k].left_en;
      pp1_r[k] <= fin[k].p;
    end
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= fin[0].valid;
  end

  // Total of the pairs, then one leftover element per stage.
  always_ff @(posedge clk) begin
    t_r[0]  <= fp_add(s01_r, s23_r);
    lf_r[0] <= lf1_r;
    pp_r[0] <= pp1_r;
    for (int j = 1; j <= HVL2_LEFT; j++) begin
      t_r[j]  <= lf_r[j-1][j-1] ? fp_add(t_r[j-1], pp_r[j-1][j-1]) : t_r[j-1];
      lf_r[j] <= lf_r[j-1];
      pp_r[j] <= pp_r[j-1];
    end
    if (!rst_n) begin
      for (int j = 0; j <= HVL2_LEFT; j++) v_r[j] <= 1'b0;
    end else begin
      v_r[0] <= v1_r;
      for (int j = 1; j <= HVL2_LEFT; j++) v_r[j] <= v_r[j-1];
    end
  end

  // Any NaN leaves as the canonical quiet NaN.
  always_comb begin
    fin_bits = t_r[HVL2_LEFT];
    if ((&fin_bits[30:23]) && (|fin_bits[22:0])) fin_bits = FP_QNAN;
  end

  assign res.valid = v_r[HVL2_LEFT];
  assign res.bits  = fin_bits;

endmodule

### sv/half_vector_l2_squared_distance.sv
// A distance passes the request, lane and merge registers, then the result queue.
// Throughput: one request per cycle; four element pairs go into four lanes at once.
// The lane sums' single-register add loop sets this rate whenever ready is high.
// A 16-entry result queue holds distances; ready drops only for a vector-ending
// request while 16 distances are queued or in flight.
// Reset (synchronous, rst_n low) clears sums, index and queue; length becomes 1.
// ----------------------------------------------------------------------------
// half_vector_l2_squared_distance: squared L2 distance, binary16 in, binary32 out
// Four lanes accumulate squared differences; a merge stage adds the lanes
// and the leftover elements, and a result queue holds the distances.
// ----------------------------------------------------------------------------
module half_vector_l2_squared_distance
  import hvl2_pkg::*;
#(
  parameter int MAX_LENGTH = 16384
) (
  input  logic          clk,
  input  logic          rst_n,
  hvl2_in_if.sink       in_req,
  hvl2_out_if.source    out_res,
  input  logic          cfg_we,
  input  logic [13:0]   cfg_data
);

  logic [13:0]         dim_r, dim_nxt, idx_r, idx_nxt;
  logic [14:0]         body, pos [HVL2_LANES];
  logic                last_now, acc, pop;
  logic [FIFO_AW:0]    pend_r, pend_nxt, cnt_r;
  logic [FIFO_AW-1:0]  wr_r, rd_r;
  logic [31:0]         fifo_mem [FIFO_DEPTH];
  logic [15:0]         a_in [HVL2_LANES], b_in [HVL2_LANES];
  logic [15:0]         a_r [HVL2_LANES], b_r [HVL2_LANES];
  lane_ctl_t           ctl_r [HVL2_LANES];
  lane_fin_t           fin [HVL2_LANES];
  res_t                res;

  assign a_in[0] = in_req.a_lane0;
  assign a_in[1] = in_req.a_lane1;
  assign a_in[2] = in_req.a_lane2;
  assign a_in[3] = in_req.a_lane3;
  assign b_in[0] = in_req.b_lane0;
  assign b_in[1] = in_req.b_lane1;
  assign b_in[2] = in_req.b_lane2;
  assign b_in[3] = in_req.b_lane3;

  // Position in the vector and the request that ends it.
  always_comb begin
    body     = {1'b0, dim_r[13:2], 2'b00};
    last_now = ({1'b0, idx_r} + 15'd4) >= {1'b0, dim_r};
    for (int k = 0; k < HVL2_LANES; k++) pos[k] = {1'b0, idx_r} + 15'(k);
  end

  assign in_req.ready = !last_now || (pend_r < (FIFO_AW+1)'(FIFO_DEPTH));
  assign acc          = in_req.valid && in_req.ready;
  assign pop          = out_res.valid && out_res.ready;

  // Length register and element index.
  always_comb begin
    dim_nxt = dim_r;
    idx_nxt = idx_r;
    if (cfg_we) begin
      dim_nxt = (32'(cfg_data) > MAX_LENGTH) ? 14'(MAX_LENGTH) : cfg_data;
      idx_nxt = '0;
    end else if (acc) begin
      idx_nxt = last_now ? 14'd0 : idx_r + 14'd4;
    end
    pend_nxt = pend_r + (FIFO_AW+1)'(acc && last_now) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r  <= 14'd1;
      idx_r  <= '0;
      pend_r <= '0;
    end else begin
      dim_r  <= dim_nxt;
      idx_r  <= idx_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Request register feeding the lanes.
  always_ff @(posedge clk) begin
    for (int k = 0; k < HVL2_LANES; k++) begin
      a_r[k] <= a_in[k];
      b_r[k] <= b_in[k];
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k].valid   <= acc;
        ctl_r[k].acc_en  <= pos[k] < body;
        ctl_r[k].left_en <= (pos[k] >= body) && (pos[k] < {1'b0, dim_r});
        ctl_r[k].last    <= last_now;
      end
    end
  end

  for (genvar g = 0; g < HVL2_LANES; g++) begin : g_lane
    hvl2_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .clr   (cfg_we),
      .ctl   (ctl_r[g]),
      .a     (a_r[g]),
      .b     (b_r[g]),
      .fin   (fin[g])
    );
  end

  hvl2_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .fin   (fin),
    .res   (res)
  );

  // Result queue; space is reserved when the vector-ending request is taken.
  always_ff @(posedge clk) begin
    if (res.valid) fifo_mem[wr_r] <= res.bits;
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (res.valid) wr_r <= wr_r + 1'b1;
      if (pop)       rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (FIFO_AW+1)'(res.valid) - (FIFO_AW+1)'(pop);
    end
  end

  assign out_res.valid         = cnt_r != '0;
  assign out_res.distance_bits = fifo_mem[rd_r];

endmodule

### sv/hvl2_checker.sv
// ----------------------------------------------------------------------------
// hvl2_checker: port-level checks
// Watches the top level's handshakes and configuration port over time.
// ----------------------------------------------------------------------------
module hvl2_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_bits,
  input logic        cfg_we,
  input logic [13:0] cfg_data
);

  // A reset leaves no result queued.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_bits))
    else $error("result changed while stalled");

  // After a long vector is set up, the first request cannot end it.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_data > 14'd4) |=> in_ready)
    else $error("not ready at the start of a new vector");

  // Ready is known whenever a request is taken.
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !$isunknown(in_ready))
    else $error("ready unknown during a request");

endmodule

bind half_vector_l2_squared_distance hvl2_checker u_hvl2_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_bits  (out_res.distance_bits),
  .cfg_we    (cfg_we),
  .cfg_data  (cfg_data)
);

### sim/hvl2_distance_checker.sv
// ----------------------------------------------------------------------------
// hvl2_distance_checker: distance predictor and result scoreboard
// Watches the request, result and register ports. It computes each squared
// distance with its own binary32 arithmetic and compares the results in order.
// ----------------------------------------------------------------------------
module hvl2_distance_checker
  import hvl2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  hvl2_in_if          in_ch,
  hvl2_out_if         out_ch,
  input  logic        cfg_we,
  input  logic [13:0] cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_CAP = 16384;

  logic [31:0] lane_acc [HVL2_LANES];
  int          next_elem;
  int          vec_len;
  logic [31:0] distance_q [$];

  // Rounds the exact value s * m * 2^e to binary32, nearest even.
  function automatic logic [31:0] f32_round(input logic s, input logic [319:0] m, input int e);
    int           p;
    int           ex;
    int           q;
    int           sh;
    logic [319:0] mant;
    logic [319:0] rem;
    logic [319:0] half;
    logic [31:0]  bits;
    if (m == '0) return {s, 31'b0};
    p = 0;
    for (int i = 0; i < 320; i++) if (m[i]) p = i;
    ex = p + e;
    if (ex > 127) return {s, 8'hFF, 23'b0};
    q  = (ex < -126) ? -149 : ex - 23;
    sh = q - e;
    if (sh <= 0) begin
      mant = m << (-sh);
    end else begin
      mant = m >> sh;
      rem  = m & ((320'd1 << sh) - 320'd1);
      half = 320'd1 << (sh - 1);
      if (rem > half || (rem == half && mant[0])) mant = mant + 320'd1;
    end
    // A carry out of the mantissa lands in the exponent field by itself.
    if (ex < -126) bits = mant[31:0];
    else           bits = (32'(ex + 126) << 23) + mant[31:0];
    return {s, 31'b0} | bits;
  endfunction

  function automatic logic f32_is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic f32_is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  // Splits a finite binary32 into sign, integer significand and exponent.
  function automatic void f32_split(input logic [31:0] x, output logic s,
                                    output logic [319:0] m, output int e);
    s = x[31];
    if (x[30:23] == 8'd0) begin
      m = 320'(x[22:0]);
      e = -149;
    end else begin
      m = 320'({1'b1, x[22:0]});
      e = int'(x[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
    logic         sa;
    logic         sb;
    logic [319:0] ma;
    logic [319:0] mb;
    int           ea;
    int           eb;
    int           emin;
    if (f32_is_nan(a) || f32_is_nan(b)) return FP_QNAN;
    if (f32_is_inf(a) && f32_is_inf(b) && a[31] != b[31]) return FP_QNAN;
    if (f32_is_inf(a)) return a;
    if (f32_is_inf(b)) return b;
    f32_split(a, sa, ma, ea);
    f32_split(b, sb, mb, eb);
    emin = (ea < eb) ? ea : eb;
    ma = ma << (ea - emin);
    mb = mb << (eb - emin);
    if (sa == sb) return f32_round(sa, ma + mb, emin);
    // Exact cancellation gives positive zero.
    if (ma == mb) return FP_ZERO;
    if (ma > mb) return f32_round(sa, ma - mb, emin);
    return f32_round(sb, mb - ma, emin);
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    logic         sa;
    logic         sb;
    logic [319:0] ma;
    logic [319:0] mb;
    int           ea;
    int           eb;
    logic         zero_a;
    logic         zero_b;
    zero_a = (a[30:0] == 31'd0);
    zero_b = (b[30:0] == 31'd0);
    if (f32_is_nan(a) || f32_is_nan(b)) return FP_QNAN;
    if ((f32_is_inf(a) && zero_b) || (f32_is_inf(b) && zero_a)) return FP_QNAN;
    if (f32_is_inf(a) || f32_is_inf(b)) return {a[31] ^ b[31], 8'hFF, 23'b0};
    f32_split(a, sa, ma, ea);
    f32_split(b, sb, mb, eb);
    if (zero_a || zero_b) return {sa ^ sb, 31'b0};
    return f32_round(sa ^ sb, ma * mb, ea + eb);
  endfunction

  // Exact binary16 to binary32 conversion.
  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'b0};
    if (h[14:10] == 5'd0) return f32_round(h[15], 320'(h[9:0]), -24);
    return f32_round(h[15], 320'({1'b1, h[9:0]}), int'(h[14:10]) - 25);
  endfunction

  function automatic logic [31:0] squared_diff(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] d;
    d = f32_add(half_to_f32(a), half_to_f32(b) ^ 32'h8000_0000);
    return f32_mul(d, d);
  endfunction

  // Scoreboard: register writes, predictions on requests, compares on results.
  always @(posedge clk) begin
    logic [15:0] av [HVL2_LANES];
    logic [15:0] bv [HVL2_LANES];
    logic [31:0] total;
    logic [31:0] want;
    int          body;
    int          el;
    if (!rst_n) begin
      foreach (lane_acc[k]) lane_acc[k] = FP_ZERO;
      next_elem  <= 0;
      vec_len    <= 1;
      mismatches <= 0;
      checked    <= 0;
      distance_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (distance_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("ERROR: unexpected distance %h", out_ch.distance_bits);
        end else begin
          want = distance_q.pop_front();
          checked <= checked + 1;
          if (want !== out_ch.distance_bits) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("ERROR: distance expected %h, got %h", want, out_ch.distance_bits);
          end
        end
      end
      if (cfg_we) begin
        // Writing the length also starts a new vector.
        vec_len <= (int'(cfg_data) > LEN_CAP) ? LEN_CAP : int'(cfg_data);
        foreach (lane_acc[k]) lane_acc[k] = FP_ZERO;
        next_elem <= 0;
      end else if (in_ch.valid && in_ch.ready) begin
        av = '{in_ch.a_lane0, in_ch.a_lane1, in_ch.a_lane2, in_ch.a_lane3};
        bv = '{in_ch.b_lane0, in_ch.b_lane1, in_ch.b_lane2, in_ch.b_lane3};
        body = (vec_len / 4) * 4;
        for (int k = 0; k < HVL2_LANES; k++)
          if (next_elem + k < body) lane_acc[k] = f32_add(lane_acc[k], squared_diff(av[k], bv[k]));
        if (next_elem + HVL2_LANES < vec_len) begin
          next_elem <= next_elem + HVL2_LANES;
        end else begin
          total = f32_add(f32_add(lane_acc[0], lane_acc[1]), f32_add(lane_acc[2], lane_acc[3]));
          // Leftover elements are added one by one in element order.
          for (int k = 0; k < HVL2_LANES; k++) begin
            el = next_elem + k;
            if (el >= body && el < vec_len) total = f32_add(total, squared_diff(av[k], bv[k]));
          end
          if (f32_is_nan(total)) total = FP_QNAN;
          distance_q.push_back(total);
          foreach (lane_acc[k]) lane_acc[k] = FP_ZERO;
          next_elem <= 0;
        end
      end
    end
    outstanding <= distance_q.size();
  end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the squared L2 distance block
// Drives binary16 vector pairs under several vector lengths and idle patterns,
// holds the result port off once to fill the block, and reports the result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TARGET_REQS  = 1800;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 14;
  localparam int LONG_LEN     = 1203;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [13:0] cfg_data;
  idle_mode_t  idle_mode;
  logic        hold_req;
  int          hold_cnt;
  int          cycles;
  int          sent;
  int          settings;
  int          mismatches;
  int          outstanding;
  int          checked;

  hvl2_in_if  req_ch ();
  hvl2_out_if res_ch ();

  half_vector_l2_squared_distance dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_ch),
    .out_res  (res_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  hvl2_distance_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (req_ch),
    .out_ch      (res_ch),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run time limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result port: random stalls, plus one long hold-off when requested.
  always @(negedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      res_ch.ready <= 1'b0;
      hold_cnt     <= hold_cnt + 1;
    end else begin
      if (!hold_req) hold_cnt <= 0;
      case (idle_mode)
        IDLE_RECEIVER: res_ch.ready <= ($urandom_range(0, 99) >= 84);
        IDLE_BOTH:     res_ch.ready <= ($urandom_range(0, 99) >= 15);
        default:       res_ch.ready <= 1'b1;
      endcase
    end
  end

  function automatic logic sender_gap();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 84;
      IDLE_BOTH:   return $urandom_range(0, 99) < 15;
      default:     return 1'b0;
    endcase
  endfunction

  // Binary16 patterns that sit on the corners of the format.
  function automatic logic [15:0] corner_half(input int i);
    logic [15:0] c [12];
    c = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00, 16'hFFFF,
          16'h7BFF, 16'hFBFF, 16'h0001, 16'h83FF, 16'h3C00, 16'h0400};
    return c[i % 12];
  endfunction

  // Mostly well-scaled values, some raw patterns and a few corners.
  function automatic logic [15:0] pick_half();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return {1'($urandom), 5'($urandom_range(4, 26)), 10'($urandom)};
    if (r < 19) return 16'($urandom);
    return corner_half($urandom_range(0, 11));
  endfunction

  task automatic send_request(input logic [3:0][15:0] a, input logic [3:0][15:0] b);
    @(negedge clk);
    while (sender_gap()) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.a_lane0 <= a[0];
    req_ch.a_lane1 <= a[1];
    req_ch.a_lane2 <= a[2];
    req_ch.a_lane3 <= a[3];
    req_ch.b_lane0 <= b[0];
    req_ch.b_lane1 <= b[1];
    req_ch.b_lane2 <= b[2];
    req_ch.b_lane3 <= b[3];
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_random(input int count);
    logic [3:0][15:0] a;
    logic [3:0][15:0] b;
    for (int i = 0; i < count; i++) begin
      foreach (a[k]) a[k] = pick_half();
      foreach (b[k]) b[k] = pick_half();
      send_request(a, b);
    end
  endtask

  // Lets every pending distance drain, then writes the length register.
  task automatic set_length(input int len);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= 14'(len);
    @(negedge clk);
    cfg_we   <= 1'b0;
    settings++;
  endtask

  function automatic int reqs_per_vector(input int len);
    return (len == 0) ? 1 : (len + 3) / 4;
  endfunction

  initial begin
    logic [3:0][15:0] a;
    logic [3:0][15:0] b;
    int               len;
    int               phase;
    int               lens [6];
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    idle_mode    = IDLE_NONE;
    hold_req     = 1'b0;
    cycles       = 0;
    sent         = 0;
    settings     = 0;
    req_ch.valid = 1'b0;
    {req_ch.a_lane0, req_ch.a_lane1, req_ch.a_lane2, req_ch.a_lane3} = '0;
    {req_ch.b_lane0, req_ch.b_lane1, req_ch.b_lane2, req_ch.b_lane3} = '0;
    res_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Corner patterns in all four lanes: infinities, NaNs, subnormals, extremes.
    set_length(4);
    for (int i = 0; i < 10; i++) begin
      foreach (a[k]) a[k] = corner_half(i + k);
      foreach (b[k]) b[k] = corner_half(3 * i + k + 1);
      send_request(a, b);
    end
    // Zero length: every request gives positive zero.
    set_length(0);
    send_random(2);
    // Short vectors with leftover elements and lanes past the end.
    lens = '{1, 2, 3, 5, 6, 7};
    foreach (lens[i]) begin
      set_length(lens[i]);
      send_random(reqs_per_vector(lens[i]));
    end
    // A register write in the middle of a vector abandons it.
    set_length(40);
    send_random(3);
    set_length(9);
    send_random(3);

    // Long hold-off on the result side while length-one vectors keep coming.
    set_length(1);
    hold_req = 1'b1;
    send_random(60);
    hold_req = 1'b0;

    // One long vector with a leftover tail.
    set_length(LONG_LEN);
    send_random(reqs_per_vector(LONG_LEN));

    // Random lengths, vector counts and idle patterns.
    phase = 0;
    while (sent < TARGET_REQS) begin
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(0, 3);
        1, 2:    len = $urandom_range(25, 200);
        default: len = $urandom_range(1, 24);
      endcase
      set_length(len);
      idle_mode = idle_mode_t'(phase % 4);
      send_random(reqs_per_vector(len) * $urandom_range(1, 6));
      phase++;
    end
    idle_mode = IDLE_NONE;

    // Drain and settle.
    @(negedge clk);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d requests over %0d length settings; %0d distances checked.",
             sent, settings, checked);
    $display("Lengths ran from 0 to %0d under all idle patterns and one long hold-off.",
             LONG_LEN);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/hvl2_pkg.sv
sv/hvl2_in_if.sv
sv/hvl2_out_if.sv
sv/hvl2_lane.sv
sv/hvl2_merge.sv
sv/half_vector_l2_squared_distance.sv
sv/hvl2_checker.sv
sim/hvl2_distance_checker.sv
sim/testbench.sv
